@@ hw/rtl/hxd_pkg.sv @@
// Shared types, constants and the hex digit decoder for the hex dump text decoder.
// No dependencies; every other file of the block imports this package.
package hxd_pkg;

    // Line offset width; the emitted address is always ADDR_OUT_W wide
    localparam int ADDR_WIDTH = 48;
    localparam int ADDR_OUT_W = 48;
    localparam int SUM_W      = (ADDR_WIDTH > ADDR_OUT_W) ? ADDR_WIDTH : ADDR_OUT_W;

    localparam int COL_W     = 9;
    localparam int STYLE_W   = 2;
    localparam int BASE_W    = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 48;
    localparam int DIGIT_W   = 5;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 56;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUMP_STYLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE       = 2'd2;

    // Dump styles (any other code behaves as bits style)
    localparam logic [STYLE_W-1:0] STYLE_NORMAL = 2'd0;
    localparam logic [STYLE_W-1:0] STYLE_PLAIN  = 2'd1;
    localparam logic [STYLE_W-1:0] STYLE_BITS   = 2'd2;

    localparam logic [COL_W-1:0] COLUMNS_RESET = 9'd16;
    localparam logic [COL_W-1:0] PHASE_OFFSET  = 9'h1FF;

    // Digit slot value meaning "no digit" (minus one)
    localparam logic [DIGIT_W-1:0] NO_DIGIT = 5'h1F;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [3:0] BIT_COUNT_MAX = 4'd15;

    typedef struct packed {
        logic [COL_W-1:0]   columns;
        logic [STYLE_W-1:0] dump_style;
        logic [BASE_W-1:0]  base_offset;
    } hxd_cfg_t;

    typedef struct packed {
        logic                  emit;
        logic [7:0]            data_byte;
        logic [ADDR_OUT_W-1:0] address;
    } hxd_result_t;

    // Hex digit value, or NO_DIGIT for anything else
    function automatic logic [DIGIT_W-1:0] hex_value(input logic [7:0] c);
        logic [DIGIT_W-1:0] v;
        v = NO_DIGIT;
        if (c >= 8'h30 && c <= 8'h39) v = DIGIT_W'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) v = DIGIT_W'(c - 8'h57);
        if (c >= 8'h41 && c <= 8'h46) v = DIGIT_W'(c - 8'h37);
        return v;
    endfunction

endpackage

@@ hw/rtl/hexdump_text_to_binary.sv @@
// Top level of the hex dump text decoder: input register, configuration, core, result stage.
// Depends on hxd_pkg, hxd_core and hxd_out_stage.
//
//  channel | dir | payload (low bit first)             | handshake
//  --------+-----+-------------------------------------+------------------
//  s_      | in  | tdata[7:0] ch                       | s_tvalid/s_tready
//  m_      | out | tdata[7:0] data_byte, [55:8] address| m_tvalid/m_tready
//  cfg_    | in  | cfg_index, cfg_wdata                | cfg_wr_en
//
// One character per cycle is sustained while m_tready keeps the result flowing: a
// character is held in the input register while the core decodes it, and its byte
// (if any) is then loaded into the result register, which drives m_tvalid.
// Reset (aresetn low, synchronous) empties both registers and restores the decoder
// to the offset phase with columns 16, normal style and base 0.
// A stalled result holds the core; the input register still takes one transfer.
module hexdump_text_to_binary (
    input  logic                            aclk,
    input  logic                            aresetn,
    // slave stream: ch
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hxd_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] ch
    // master stream: data_byte, address
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hxd_pkg::OUT_TDATA_W-1:0] m_tdata,   // [7:0] data_byte, [55:8] address
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [hxd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hxd_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
    import hxd_pkg::*;

    hxd_cfg_t    cfg_reg;
    hxd_result_t result;

    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       out_free;
    logic       fire;

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.columns     <= COLUMNS_RESET;
            cfg_reg.dump_style  <= STYLE_NORMAL;
            cfg_reg.base_offset <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_COLUMNS:    cfg_reg.columns     <= cfg_wdata[COL_W-1:0];
                CFG_DUMP_STYLE: cfg_reg.dump_style  <= cfg_wdata[STYLE_W-1:0];
                CFG_BASE:       cfg_reg.base_offset <= cfg_wdata[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    // The core advances whenever the result slot is free or being emptied
    assign out_free = !m_tvalid || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register: take a transfer when empty or when its character is consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ch_reg <= s_tdata[7:0];
        end
    end

    hxd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .ch      (ch_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    hxd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire && result.emit),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ hw/rtl/hxd_core.sv @@
// Decoder state and per-character update of the hex dump text decoder.
// Depends on hxd_pkg.
module hxd_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  logic [7:0]           ch,
    input  hxd_pkg::hxd_cfg_t    cfg,
    output hxd_pkg::hxd_result_t result
);
    import hxd_pkg::*;

    logic                  skipping_line_reg, skipping_line_next;
    logic                  ignore_garbage_reg, ignore_garbage_next;
    logic [DIGIT_W-1:0]    digit_newest_reg, digit_newest_next;
    logic [DIGIT_W-1:0]    digit_previous_reg, digit_previous_next;
    logic [DIGIT_W-1:0]    digit_oldest_reg, digit_oldest_next;
    logic [COL_W-1:0]      line_column_reg, line_column_next;
    logic [7:0]            bit_shift_reg, bit_shift_next;
    logic [3:0]            bit_count_reg, bit_count_next;
    logic [ADDR_WIDTH-1:0] line_offset_reg, line_offset_next;

    logic                  hexlike;
    logic [DIGIT_W-1:0]    hv;
    logic [COL_W-1:0]      column_inc;
    logic [SUM_W-1:0]      addr_sum;
    logic [ADDR_WIDTH-1:0] addr_wrapped;

    assign hexlike    = (cfg.dump_style == STYLE_NORMAL) || (cfg.dump_style == STYLE_PLAIN);
    assign hv         = hex_value(ch);
    assign column_inc = line_column_reg + COL_W'(1);

    // Base is sign-extended, offset zero-extended, then wrapped
    assign addr_sum     = SUM_W'(signed'(cfg.base_offset)) + SUM_W'(line_offset_reg);
    assign addr_wrapped = addr_sum[ADDR_WIDTH-1:0];

    always_comb begin
        skipping_line_next  = skipping_line_reg;
        ignore_garbage_next = ignore_garbage_reg;
        digit_newest_next   = digit_newest_reg;
        digit_previous_next = digit_previous_reg;
        digit_oldest_next   = digit_oldest_reg;
        line_column_next    = line_column_reg;
        bit_shift_next      = bit_shift_reg;
        bit_count_next      = bit_count_reg;
        line_offset_next    = line_offset_reg;
        result.emit         = 1'b0;
        result.data_byte    = 8'd0;
        result.address      = ADDR_OUT_W'(addr_wrapped);

        if (fire && ch != CHAR_CR) begin
            if (skipping_line_reg) begin
                if (ch == CHAR_LF) begin
                    if (cfg.dump_style != STYLE_PLAIN) line_offset_next = '0;
                    line_column_next    = PHASE_OFFSET;
                    ignore_garbage_next = 1'b1;
                    skipping_line_next  = 1'b0;
                end
            end else if (!(cfg.dump_style == STYLE_PLAIN &&
                           (ch == CHAR_SPACE || ch == CHAR_LF || ch == CHAR_TAB))) begin
                if (hexlike) begin
                    digit_oldest_next   = digit_previous_reg;
                    digit_previous_next = digit_newest_reg;
                end
                digit_newest_next = hv;

                // Drop leading garbage while garbage is still tolerated
                if (!(hv[DIGIT_W-1] && ignore_garbage_reg)) begin
                    if (!hexlike && (ch == CHAR_ZERO || ch == CHAR_ONE)) begin
                        bit_shift_next = {bit_shift_reg[6:0], ch[0]};
                        if (bit_count_reg < BIT_COUNT_MAX)
                            bit_count_next = bit_count_reg + 4'd1;
                    end
                    ignore_garbage_next = 1'b0;

                    if (cfg.dump_style != STYLE_PLAIN && line_column_reg >= cfg.columns) begin
                        // Offset phase: a non-digit ends it, a digit shifts in
                        if (hv[DIGIT_W-1]) begin
                            line_column_next = '0;
                            if (!hexlike) bit_count_next = '0;
                        end else begin
                            line_offset_next = {line_offset_reg[ADDR_WIDTH-5:0], hv[3:0]};
                        end
                    end else begin
                        if (hexlike) begin
                            if (!digit_newest_reg[DIGIT_W-1] && !hv[DIGIT_W-1]) begin
                                result.emit       = 1'b1;
                                result.data_byte  = {digit_newest_reg[3:0], hv[3:0]};
                                line_offset_next  = line_offset_reg + ADDR_WIDTH'(1);
                                digit_newest_next = NO_DIGIT;
                                if (cfg.dump_style == STYLE_NORMAL) begin
                                    line_column_next = column_inc;
                                    if (column_inc >= cfg.columns && ch != CHAR_LF)
                                        skipping_line_next = 1'b1;
                                end
                            end else if (hv[DIGIT_W-1] && digit_newest_reg[DIGIT_W-1] &&
                                         digit_previous_reg[DIGIT_W-1]) begin
                                // A non-digit with both earlier digit slots empty: give up on the line
                                if (ch != CHAR_LF) skipping_line_next = 1'b1;
                            end
                        end else if (bit_count_next == BITS_PER_BYTE) begin
                            result.emit      = 1'b1;
                            result.data_byte = bit_shift_next;
                            line_offset_next = line_offset_reg + ADDR_WIDTH'(1);
                            bit_shift_next   = '0;
                            bit_count_next   = '0;
                            line_column_next = column_inc;
                            if (column_inc >= cfg.columns && ch != CHAR_LF)
                                skipping_line_next = 1'b1;
                        end

                        if (ch == CHAR_LF) begin
                            if (cfg.dump_style != STYLE_PLAIN) line_offset_next = '0;
                            line_column_next    = PHASE_OFFSET;
                            ignore_garbage_next = 1'b1;
                            skipping_line_next  = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skipping_line_reg  <= 1'b0;
            ignore_garbage_reg <= 1'b1;
            digit_newest_reg   <= NO_DIGIT;
            digit_previous_reg <= '0;
            digit_oldest_reg   <= '0;
            line_column_reg    <= PHASE_OFFSET;
            bit_shift_reg      <= '0;
            bit_count_reg      <= '0;
            line_offset_reg    <= '0;
        end else begin
            skipping_line_reg  <= skipping_line_next;
            ignore_garbage_reg <= ignore_garbage_next;
            digit_newest_reg   <= digit_newest_next;
            digit_previous_reg <= digit_previous_next;
            digit_oldest_reg   <= digit_oldest_next;
            line_column_reg    <= line_column_next;
            bit_shift_reg      <= bit_shift_next;
            bit_count_reg      <= bit_count_next;
            line_offset_reg    <= line_offset_next;
        end
    end

    // A line being skipped never tolerates garbage
    assert property (@(posedge aclk) disable iff (!aresetn)
        skipping_line_reg |-> !ignore_garbage_reg)
        else $error("skipping_line set while garbage still tolerated");

    // Carriage returns leave the decoder untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ch == CHAR_CR) |=> ($stable(line_offset_reg) && $stable(skipping_line_reg)
                                     && $stable(digit_newest_reg)))
        else $error("carriage return changed decoder state");

    // A hex pair consumes its digits
    assert property (@(posedge aclk) disable iff (!aresetn)
        (result.emit && hexlike) |=> (digit_newest_reg == NO_DIGIT))
        else $error("digit slot not cleared after a hex pair");

endmodule

@@ hw/rtl/hxd_out_stage.sv @@
// Result register of the hex dump text decoder, driving the master stream side.
// Depends on hxd_pkg.
module hxd_out_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             load,
    input  hxd_pkg::hxd_result_t             result,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [hxd_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import hxd_pkg::*;

    logic                  valid_reg;
    logic [7:0]            byte_reg;
    logic [ADDR_OUT_W-1:0] address_reg;

    // Hold until the transfer completes; load only arrives when the slot is free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg    <= result.data_byte;
            address_reg <= result.address;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {address_reg, byte_reg};

endmodule
